// ----- src/prqs_pkg.sv -----
// ----------------------------------------------------------------------------
// prqs_pkg
// Shared types and codes for the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

    // Operation codes carried in the input word
    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_READY    = 3'd1,
        OP_BLOCK    = 3'd2,
        OP_CHPRI    = 3'd3,
        OP_EXIT     = 3'd4,
        OP_SCHEDULE = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ALREADY    = 3'd1,
        ST_NOT_READY  = 3'd2,
        ST_NOT_HEAD   = 3'd3,
        ST_NO_FREE    = 3'd4,
        ST_NONE_READY = 3'd5,
        ST_BAD_SLOT   = 3'd6
    } t_status;

    localparam int OP_W    = 3;
    localparam int THR_W   = 3;
    localparam int PRI_W   = 5;
    localparam int OPRI_W  = 4;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SCAN_SLOT = 9'b000000010,
        S_SCAN_LVL  = 9'b000000100,
        S_SCHED     = 9'b000001000,
        S_EXEC      = 9'b000010000,
        S_APP_RD    = 9'b000100000,
        S_APP_WR    = 9'b001000000,
        S_BLK       = 9'b010000000,
        S_DONE      = 9'b100000000
    } t_state;

endpackage

// ----- src/priority_ready_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Thread-slot table with one FIFO ready list per priority level, run by a
// small sequencer with a slot scan counter and a separate level scan counter.
// ----------------------------------------------------------------------------
// Ready and change pass exec, append read and append write; block passes
// exec and the block state; exit ends in exec. Create scans slots one per
// cycle, schedule scans levels one per cycle. One word at a time, the next
// word taken once the result loads and the sequencer is idle; s_axis_tready
// is high only when idle, and a new word is taken while the previous result
// still waits. Reset (synchronous) empties lists, frees slots.
module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int THREADS = 8,
    parameter int LEVELS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] operation, [5:3] thread, [10:6] priority_req (signed), rest zero
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [2:0] status, [5:3] thread_out, [9:6] old_priority, rest zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // ---------------- sequencer and item registers ----------------
    t_state               r_state;
    t_op                  r_op;
    logic [TW-1:0]        r_slot;      // slot acted on, also the create scan index
    logic                 r_bad;       // thread field at or above THREADS
    logic [PRI_W-1:0]     r_praw;
    logic [LW-1:0]        r_lvl;       // schedule scan index

    t_status              r_status;
    logic [THR_W-1:0]     r_tout;
    logic [OPRI_W-1:0]    r_oldp;

    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    // ---------------- slot table (flops, cleared by reset) ----------------
    logic [THREADS-1:0]   r_slot_used;
    logic [THREADS-1:0]   r_slot_ready;
    logic [THREADS-1:0]   r_slot_has_next;
    logic [LW-1:0]        r_slot_prio [THREADS];
    logic [LEVELS-1:0]    r_level_nonempty;

    // ---------------- list memories (no reset, guarded by flags) ----------------
    logic [TW-1:0]        mem_head [LEVELS];
    logic [TW-1:0]        mem_tail [LEVELS];
    logic [TW-1:0]        mem_next [THREADS];
    logic [TW-1:0]        r_head_q;
    logic [TW-1:0]        r_tail_q;
    logic [TW-1:0]        r_next_q;

    // ---------------- decode of the incoming word ----------------
    logic                 w_accept;
    logic [TW+THR_W-1:0]  w_thr_ext;
    logic [LW+PRI_W-1:0]  w_praw_ext;
    logic [LW-1:0]        w_preq;       // request clamped to the top level
    logic                 w_pneg;
    logic [LW-1:0]        w_prio;       // current level of r_slot
    logic [TW+THR_W-1:0]  w_slot_ext;
    logic [LW+OPRI_W-1:0] w_prio_ext;
    logic [TW+THR_W-1:0]  w_head_ext;
    logic [LW-1:0]        w_head_raddr;
    logic                 w_head_we;
    logic [TW-1:0]        w_head_wdata;

    assign w_accept   = s_axis_tvalid & s_axis_tready;
    assign w_thr_ext  = {{TW{1'b0}}, s_axis_tdata[5:3]};
    assign w_praw_ext = {{LW{1'b0}}, r_praw};
    assign w_pneg     = r_praw[PRI_W-1];
    assign w_preq     = (w_praw_ext >= (LW+PRI_W)'(LEVELS)) ? LW'(LEVELS - 1)
                                                            : w_praw_ext[LW-1:0];
    assign w_prio     = r_slot_prio[r_slot];
    assign w_slot_ext = {{THR_W{1'b0}}, r_slot};
    assign w_prio_ext = {{OPRI_W{1'b0}}, w_prio};
    assign w_head_ext = {{THR_W{1'b0}}, r_head_q};

    // head memory is read at the scan level during schedule, else at the
    // slot's own level
    assign w_head_raddr = (r_state == S_SCAN_LVL) ? r_lvl : w_prio;

    // head write: new head on append to an empty list, successor on block
    always_comb begin
        w_head_we    = 1'b0;
        w_head_wdata = r_slot;
        if (r_state == S_APP_WR && !r_level_nonempty[w_prio]) begin
            w_head_we = 1'b1;
        end else if (r_state == S_BLK && r_slot_ready[r_slot]
                     && r_level_nonempty[w_prio] && r_head_q == r_slot
                     && r_slot_has_next[r_slot]) begin
            w_head_we    = 1'b1;
            w_head_wdata = r_next_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_q <= mem_head[w_head_raddr];
        if (w_head_we) begin
            mem_head[w_prio] <= w_head_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail_q <= mem_tail[w_prio];
        if (r_state == S_APP_WR) begin
            mem_tail[w_prio] <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next_q <= mem_next[r_slot];
        if (r_state == S_APP_WR && r_level_nonempty[w_prio]) begin
            mem_next[r_tail_q] <= r_slot;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_op             <= OP_CREATE;
            r_slot           <= '0;
            r_bad            <= 1'b0;
            r_praw           <= '0;
            r_lvl            <= '0;
            r_status         <= ST_OK;
            r_tout           <= '0;
            r_oldp           <= '0;
            r_out_valid      <= 1'b0;
            r_slot_used      <= '0;
            r_slot_ready     <= '0;
            r_slot_has_next  <= '0;
            r_level_nonempty <= '0;
            for (int i = 0; i < THREADS; i++) begin
                r_slot_prio[i] <= '0;
            end
        end else begin
            // S_DONE reloads the output register itself
            if (m_axis_tvalid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= t_op'(s_axis_tdata[2:0]);
                        r_praw   <= s_axis_tdata[10:6];
                        r_bad    <= (w_thr_ext >= (TW+THR_W)'(THREADS));
                        r_lvl    <= '0;
                        r_status <= ST_OK;
                        r_tout   <= '0;
                        r_oldp   <= '0;
                        unique case (s_axis_tdata[2:0])
                            OP_CREATE: begin
                                r_slot  <= '0;
                                r_state <= S_SCAN_SLOT;
                            end
                            OP_SCHEDULE: begin
                                r_slot  <= w_thr_ext[TW-1:0];
                                r_state <= S_SCAN_LVL;
                            end
                            OP_READY, OP_BLOCK, OP_CHPRI, OP_EXIT: begin
                                r_slot  <= w_thr_ext[TW-1:0];
                                r_state <= S_EXEC;
                            end
                            default: begin
                                // undefined codes are dropped without a result
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_SCAN_SLOT: begin
                    if (!r_slot_used[r_slot]) begin
                        r_slot_used[r_slot]  <= 1'b1;
                        r_slot_ready[r_slot] <= 1'b0;
                        r_slot_prio[r_slot]  <= w_pneg ? '0 : w_preq;
                        r_tout               <= w_slot_ext[THR_W-1:0];
                        r_state              <= S_APP_RD;
                    end else if (r_slot == TW'(THREADS - 1)) begin
                        r_status <= ST_NO_FREE;
                        r_state  <= S_DONE;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end

                S_SCAN_LVL: begin
                    if (r_level_nonempty[r_lvl]) begin
                        r_state <= S_SCHED;   // head read lands next cycle
                    end else if (r_lvl == LW'(LEVELS - 1)) begin
                        r_status <= ST_NONE_READY;
                        r_state  <= S_DONE;
                    end else begin
                        r_lvl <= r_lvl + 1'b1;
                    end
                end

                S_SCHED: begin
                    r_tout  <= w_head_ext[THR_W-1:0];
                    r_state <= S_DONE;
                end

                S_EXEC: begin
                    if (r_bad || !r_slot_used[r_slot]) begin
                        r_status <= ST_BAD_SLOT;
                        r_state  <= S_DONE;
                    end else begin
                        unique case (r_op)
                            OP_READY: begin
                                if (r_slot_ready[r_slot]) begin
                                    r_status <= ST_ALREADY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_APP_RD;
                                end
                            end
                            OP_BLOCK: begin
                                if (!r_slot_ready[r_slot]) begin
                                    r_status <= ST_NOT_READY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_BLK;
                                end
                            end
                            OP_CHPRI: begin
                                if (r_slot_ready[r_slot]) begin
                                    r_status <= ST_BAD_SLOT;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_oldp <= w_prio_ext[OPRI_W-1:0];
                                    if (!w_pneg) begin
                                        r_slot_prio[r_slot] <= w_preq;
                                    end
                                    r_state <= S_APP_RD;
                                end
                            end
                            OP_EXIT: begin
                                if (r_slot_ready[r_slot]) begin
                                    r_status <= ST_BAD_SLOT;
                                end else begin
                                    r_slot_used[r_slot]     <= 1'b0;
                                    r_slot_prio[r_slot]     <= '0;
                                    r_slot_has_next[r_slot] <= 1'b0;
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_APP_RD: begin
                    // tail of the slot's level is read this cycle
                    r_state <= S_APP_WR;
                end

                S_APP_WR: begin
                    if (r_level_nonempty[w_prio]) begin
                        r_slot_has_next[r_tail_q] <= 1'b1;
                    end else begin
                        r_level_nonempty[w_prio] <= 1'b1;
                    end
                    r_slot_has_next[r_slot] <= 1'b0;
                    r_slot_ready[r_slot]    <= 1'b1;
                    r_state                 <= S_DONE;
                end

                S_BLK: begin
                    if (!r_level_nonempty[w_prio] || r_head_q != r_slot) begin
                        r_status <= ST_NOT_HEAD;
                    end else begin
                        if (!r_slot_has_next[r_slot]) begin
                            r_level_nonempty[w_prio] <= 1'b0;
                        end
                        r_slot_has_next[r_slot] <= 1'b0;
                        r_slot_ready[r_slot]    <= 1'b0;
                    end
                    r_state <= S_DONE;
                end

                S_DONE: begin
                    // wait for the output register to free up
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {{(OUT_W-OP_W-THR_W-OPRI_W){1'b0}},
                                        r_oldp, r_tout, r_status};
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- checks ----------------
    a_ready_is_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot_ready & ~r_slot_used) == '0)
        else $error("ready slot not allocated");

    a_append_not_listed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APP_WR) |-> !r_slot_ready[r_slot])
        else $error("append of a slot already in a list");

    a_none_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_NONE_READY) |-> (r_level_nonempty == '0))
        else $error("none-ready reported with a non-empty level");

    a_sched_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHED) |-> $past(r_level_nonempty[r_lvl]))
        else $error("schedule picked an empty level");

endmodule
